// ===== rtl/dnvpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnvpa_pkg
// Types and constants shared by the VM placement allocator.
// ----------------------------------------------------------------------------
package dnvpa_pkg;

  localparam int SRV_W  = 10;
  localparam int SLOT_W = 12;
  localparam int CNT_W  = 11;
  localparam int SERVER_SLOTS = 1024;

  localparam logic [1:0] REQ_BUY    = 2'd0;
  localparam logic [1:0] REQ_FIRST  = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_DIRECT = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_SLOT    = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;

  localparam logic [1:0] NODE_BOTH = 2'd0;
  localparam logic [1:0] NODE_A    = 2'd1;
  localparam logic [1:0] NODE_B    = 2'd2;
  localparam logic [1:0] NODE_NONE = 2'd3;

  localparam logic CFG_TOL = 1'b0;
  localparam logic CFG_EN  = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  server_cpu;
    logic [11:0] server_memory;
    logic [9:0]  vm_cpu;
    logic [11:0] vm_mem;
    logic        dual_node;
    logic [11:0] vm_slot;
    logic [9:0]  target_server;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  placed_server;
    logic [1:0]  placed_node;
    logic [10:0] servers_in_use;
  } rsp_t;

  typedef struct packed {
    logic [9:0]  cpu;
    logic [11:0] mem;
    logic [9:0]  acpu;
    logic [11:0] amem;
    logic [9:0]  bcpu;
    logic [11:0] bmem;
  } srv_t;

  typedef struct packed {
    logic        valid;
    logic [9:0]  server;
    logic [1:0]  node;
    logic [9:0]  cpu;
    logic [11:0] mem;
  } vm_t;

  typedef enum logic [3:0] {
    S_IDLE, S_VMRD, S_VMCHK, S_SRD, S_MUL, S_EVAL, S_DEL, S_DONE
  } state_t;

  typedef struct packed {
    logic       we;
    logic [9:0] addr;
    srv_t       data;
  } srv_wr_t;

endpackage

// ===== rtl/dual_node_vm_placement_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_node_vm_placement_allocator_core
// First-fit or direct placement of VMs on dual-node servers, state held in two RAMs.
// ----------------------------------------------------------------------------
// Request channel in_valid/in_stall carries one req_t; result channel
// out_valid/out_stall returns one rsp_t per request. The configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the ratio
// tolerance and the ratio filter enable; it is always ready.
// One request is handled at a time. A buy result is loaded into the output
// register on the accepting edge. An add or delete first reads its VM slot
// and is answered from the VM check state if refused there; else a delete
// is answered from the delete state after its server entry is read, and an
// add from the evaluate state. A first-fit add reads server entries one after
// another (read, multiply, evaluate); a placed add passes a done state with
// in_stall high. After reset a clearing pass walks the 4096-entry VM RAM, one
// entry a cycle, while in_stall is high; the server RAM needs none. A finished
// result sits in the output register until taken; the next request is
// accepted no earlier than the cycle the result is taken.
// ----------------------------------------------------------------------------
module dual_node_vm_placement_allocator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dnvpa_pkg::req_t    in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dnvpa_pkg::rsp_t    out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);
  dnvpa_pkg::state_t state, state_next;
  dnvpa_pkg::req_t   req;
  dnvpa_pkg::vm_t    vm_rd, vm_wr, vm_cur;
  dnvpa_pkg::srv_t   srv_rd, srv_new, srv_sum;
  dnvpa_pkg::srv_wr_t sw;
  logic [3:0]  tol;
  logic        chk_en;
  logic [10:0] count;
  logic [9:0]  idx;
  logic [12:0] clr;
  logic        clearing;
  logic        vm_we;
  logic [11:0] vm_addr;
  logic        ratio_ok;
  logic [1:0]  node;
  logic        accept, take;
  logic        rsp_load;
  dnvpa_pkg::rsp_t rsp_next;

  assign clearing  = !clr[12];
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;
  assign in_stall  = clearing || state != dnvpa_pkg::S_IDLE || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 4'd3;
      chk_en <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == dnvpa_pkg::CFG_TOL) begin
        tol <= cfg_data;
      end else begin
        chk_en <= cfg_data[0];
      end
    end
  end

  dnvpa_ram #(.AW(dnvpa_pkg::SLOT_W), .DW($bits(dnvpa_pkg::vm_t))) u_vm (
    .clk(clk), .we(vm_we), .addr(vm_addr), .wdata(vm_wr), .rdata(vm_rd)
  );
  dnvpa_ram #(.AW(dnvpa_pkg::SRV_W), .DW($bits(dnvpa_pkg::srv_t))) u_srv (
    .clk(clk), .we(sw.we), .addr(sw.addr), .wdata(sw.data), .rdata(srv_rd)
  );
  dnvpa_fit u_fit (
    .clk(clk), .srv(srv_rd), .vc(req.vm_cpu), .vm(req.vm_mem),
    .dual(req.dual_node), .tol(tol), .ratio_ok(ratio_ok), .node(node),
    .srv_new(srv_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dnvpa_pkg::S_IDLE;
      clr <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr <= clr + 13'd1;
      end
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (state == dnvpa_pkg::S_IDLE && accept && in_data.req_type == dnvpa_pkg::REQ_BUY &&
          count != 11'(dnvpa_pkg::SERVER_SLOTS) && in_data.server_memory != 12'd0) begin
        count <= count + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (state == dnvpa_pkg::S_VMCHK) begin
      vm_cur <= vm_rd;
    end
    if (rsp_load) begin
      out_data <= rsp_next;
    end
    if (accept) begin
      idx <= (in_data.req_type == dnvpa_pkg::REQ_DIRECT) ? in_data.target_server : '0;
    end else if (state == dnvpa_pkg::S_EVAL) begin
      idx <= idx + 10'd1;
    end
  end

  always_comb begin
    srv_sum = srv_rd;
    case (vm_cur.node)
      dnvpa_pkg::NODE_A: begin
        srv_sum.acpu = srv_rd.acpu + vm_cur.cpu;
        srv_sum.amem = srv_rd.amem + vm_cur.mem;
      end
      dnvpa_pkg::NODE_B: begin
        srv_sum.bcpu = srv_rd.bcpu + vm_cur.cpu;
        srv_sum.bmem = srv_rd.bmem + vm_cur.mem;
      end
      default: begin
        srv_sum.acpu = srv_rd.acpu + (vm_cur.cpu >> 1);
        srv_sum.amem = srv_rd.amem + (vm_cur.mem >> 1);
        srv_sum.bcpu = srv_rd.bcpu + (vm_cur.cpu >> 1);
        srv_sum.bmem = srv_rd.bmem + (vm_cur.mem >> 1);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      dnvpa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (in_data.req_type == dnvpa_pkg::REQ_BUY) ? dnvpa_pkg::S_IDLE
                                                                : dnvpa_pkg::S_VMRD;
        end
      end
      dnvpa_pkg::S_VMRD: state_next = dnvpa_pkg::S_VMCHK;
      dnvpa_pkg::S_VMCHK: begin
        if (req.req_type == dnvpa_pkg::REQ_DELETE) begin
          state_next = vm_rd.valid ? dnvpa_pkg::S_SRD : dnvpa_pkg::S_IDLE;
        end else if (vm_rd.valid || req.vm_mem == 12'd0) begin
          state_next = dnvpa_pkg::S_IDLE;
        end else if ({1'b0, idx} >= count) begin
          state_next = dnvpa_pkg::S_IDLE;
        end else begin
          state_next = dnvpa_pkg::S_SRD;
        end
      end
      dnvpa_pkg::S_SRD: begin
        state_next = (req.req_type == dnvpa_pkg::REQ_DELETE) ? dnvpa_pkg::S_DEL
                                                             : dnvpa_pkg::S_MUL;
      end
      dnvpa_pkg::S_MUL: state_next = dnvpa_pkg::S_EVAL;
      dnvpa_pkg::S_EVAL: begin
        if ((!chk_en || req.req_type == dnvpa_pkg::REQ_DIRECT || ratio_ok) &&
            node != dnvpa_pkg::NODE_NONE) begin
          state_next = dnvpa_pkg::S_DONE;
        end else if (req.req_type == dnvpa_pkg::REQ_DIRECT ||
                     {1'b0, idx} + 11'd1 >= count) begin
          state_next = dnvpa_pkg::S_IDLE;
        end else begin
          state_next = dnvpa_pkg::S_SRD;
        end
      end
      dnvpa_pkg::S_DEL:  state_next = dnvpa_pkg::S_IDLE;
      dnvpa_pkg::S_DONE: state_next = dnvpa_pkg::S_IDLE;
      default: state_next = dnvpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '0;
    rsp_next.servers_in_use = count;
    vm_we = 1'b0;
    vm_addr = req.vm_slot;
    vm_wr = '0;
    sw.we = 1'b0;
    sw.addr = idx;
    sw.data = srv_new;
    if (clearing) begin
      vm_we = 1'b1;
      vm_addr = clr[11:0];
    end
    case (state)
      dnvpa_pkg::S_IDLE: begin
        if (accept && in_data.req_type == dnvpa_pkg::REQ_BUY) begin
          rsp_load = 1'b1;
          sw.addr = count[9:0];
          sw.data.cpu = in_data.server_cpu;
          sw.data.mem = in_data.server_memory;
          sw.data.acpu = in_data.server_cpu >> 1;
          sw.data.bcpu = in_data.server_cpu >> 1;
          sw.data.amem = in_data.server_memory >> 1;
          sw.data.bmem = in_data.server_memory >> 1;
          if (count == 11'(dnvpa_pkg::SERVER_SLOTS)) begin
            rsp_next.status = dnvpa_pkg::ST_FULL;
          end else if (in_data.server_memory == 12'd0) begin
            rsp_next.status = dnvpa_pkg::ST_BADSIZE;
          end else begin
            sw.we = 1'b1;
            rsp_next.placed_server = count[9:0];
            rsp_next.servers_in_use = count + 11'd1;
          end
        end
      end
      dnvpa_pkg::S_VMCHK: begin
        sw.addr = (req.req_type == dnvpa_pkg::REQ_DELETE) ? vm_rd.server : idx;
        if (req.req_type == dnvpa_pkg::REQ_DELETE) begin
          if (!vm_rd.valid) begin
            rsp_load = 1'b1;
            rsp_next.status = dnvpa_pkg::ST_SLOT;
          end
        end else if (vm_rd.valid) begin
          rsp_load = 1'b1;
          rsp_next.status = dnvpa_pkg::ST_SLOT;
        end else if (req.vm_mem == 12'd0) begin
          rsp_load = 1'b1;
          rsp_next.status = dnvpa_pkg::ST_BADSIZE;
        end else if ({1'b0, idx} >= count) begin
          rsp_load = 1'b1;
          rsp_next.status = dnvpa_pkg::ST_NOFIT;
        end
      end
      dnvpa_pkg::S_SRD: begin
        sw.addr = (req.req_type == dnvpa_pkg::REQ_DELETE) ? vm_cur.server : idx;
      end
      dnvpa_pkg::S_EVAL: begin
        if ((!chk_en || req.req_type == dnvpa_pkg::REQ_DIRECT || ratio_ok) &&
            node != dnvpa_pkg::NODE_NONE) begin
          sw.we = 1'b1;
          vm_we = 1'b1;
          vm_wr.valid = 1'b1;
          vm_wr.server = idx;
          vm_wr.node = node;
          vm_wr.cpu = req.vm_cpu;
          vm_wr.mem = req.vm_mem;
          rsp_load = 1'b1;
          rsp_next.placed_server = idx;
          rsp_next.placed_node = node;
        end else if (req.req_type == dnvpa_pkg::REQ_DIRECT ||
                     {1'b0, idx} + 11'd1 >= count) begin
          rsp_load = 1'b1;
          rsp_next.status = dnvpa_pkg::ST_NOFIT;
        end
      end
      dnvpa_pkg::S_DEL: begin
        sw.we = 1'b1;
        sw.addr = vm_cur.server;
        sw.data = srv_sum;
        vm_we = 1'b1;
        vm_wr = vm_cur;
        vm_wr.valid = 1'b0;
        rsp_load = 1'b1;
        rsp_next.placed_server = vm_cur.server;
        rsp_next.placed_node = vm_cur.node;
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== rtl/dnvpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnvpa_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module dnvpa_ram #(
  parameter int AW = 10,
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/dnvpa_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnvpa_fit
// Fit test and node choice for one server entry; registered ratio products.
// ----------------------------------------------------------------------------
module dnvpa_fit (
  input  logic               clk,
  input  dnvpa_pkg::srv_t    srv,
  input  logic [9:0]         vc,
  input  logic [11:0]        vm,
  input  logic               dual,
  input  logic [3:0]         tol,
  output logic               ratio_ok,
  output logic [1:0]         node,
  output dnvpa_pkg::srv_t    srv_new
);
  logic [21:0] pa, pb;
  logic [23:0] sm;
  logic [33:0] lim;
  logic [21:0] d;
  logic [9:0]  hc;
  logic [11:0] hm;
  logic        fa, fb;

  always_ff @(posedge clk) begin
    pa <= srv.cpu * vm;
    pb <= vc * srv.mem;
    sm <= srv.mem * vm;
  end

  always_comb begin
    d   = (pa >= pb) ? pa - pb : pb - pa;
    lim = {10'd0, sm} * {30'd0, tol};
    ratio_ok = {12'd0, d} < lim;
  end

  always_comb begin
    hc = vc >> 1;
    hm = vm >> 1;
    srv_new = srv;
    fa = srv.acpu >= vc && srv.amem >= vm;
    fb = srv.bcpu >= vc && srv.bmem >= vm;
    node = dnvpa_pkg::NODE_NONE;
    if (dual) begin
      if (srv.acpu >= hc && srv.amem >= hm && srv.bcpu >= hc && srv.bmem >= hm) begin
        node = dnvpa_pkg::NODE_BOTH;
        srv_new.acpu = srv.acpu - hc;
        srv_new.amem = srv.amem - hm;
        srv_new.bcpu = srv.bcpu - hc;
        srv_new.bmem = srv.bmem - hm;
      end
    end else begin
      if (fa && fb) begin
        node = ({3'd0, srv.acpu} + {1'b0, srv.amem} >= {3'd0, srv.bcpu} + {1'b0, srv.bmem})
               ? dnvpa_pkg::NODE_A : dnvpa_pkg::NODE_B;
      end else if (fa) begin
        node = dnvpa_pkg::NODE_A;
      end else if (fb) begin
        node = dnvpa_pkg::NODE_B;
      end
      if (node == dnvpa_pkg::NODE_A) begin
        srv_new.acpu = srv.acpu - vc;
        srv_new.amem = srv.amem - vm;
      end else if (node == dnvpa_pkg::NODE_B) begin
        srv_new.bcpu = srv.bcpu - vc;
        srv_new.bmem = srv.bmem - vm;
      end
    end
  end
endmodule

// ===== rtl/dnvpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnvpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dnvpa_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input dnvpa_pkg::rsp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result pending");
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != dnvpa_pkg::ST_OK |->
      out_data.placed_server == '0 && out_data.placed_node == '0)
    else $error("failed transaction reports a placement");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.servers_in_use <= 11'(dnvpa_pkg::SERVER_SLOTS))
    else $error("server count out of range");
endmodule

bind dual_node_vm_placement_allocator_core dnvpa_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
